[rtl/core/ghist_pkg.sv]
package ghist_pkg;

  localparam int unsigned NumBinsDef   = 256;
  localparam int unsigned CountBitsDef = 24;

  localparam int unsigned ScaleW     = 10;
  localparam int unsigned HeightW    = 10;
  localparam int unsigned OutCountW  = 24;
  localparam int unsigned KindW      = 2;
  localparam int unsigned PixelW     = 8;

  localparam logic [ScaleW-1:0] ScaleReset = ScaleW'(300);

  localparam logic [KindW-1:0] KIND_PIXEL = 2'd0;
  localparam logic [KindW-1:0] KIND_READ  = 2'd1;
  localparam logic [KindW-1:0] KIND_CLEAR = 2'd2;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [PixelW-1:0] gray_pixel;
    logic [PixelW-1:0] bin_select;
  } item_t;

  typedef struct packed {
    logic [OutCountW-1:0] bin_count;
    logic [HeightW-1:0]   bin_height;
    logic [OutCountW-1:0] peak_count;
  } result_t;

endpackage

[rtl/core/ghist_mem.sv]
module ghist_mem #(
  parameter int unsigned DEPTH = ghist_pkg::NumBinsDef,
  parameter int unsigned WIDTH = ghist_pkg::CountBitsDef
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/ghist_scale.sv]
module ghist_scale #(
  parameter int unsigned COUNT_BITS = ghist_pkg::CountBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [COUNT_BITS-1:0]         count_i,
  input  logic [COUNT_BITS-1:0]         peak_i,
  input  logic [ghist_pkg::ScaleW-1:0]  scale_i,
  output logic                          done_o,
  output logic [ghist_pkg::HeightW-1:0] height_o
);

  localparam int unsigned HW     = ghist_pkg::HeightW;
  localparam int unsigned ProdW  = COUNT_BITS + ghist_pkg::ScaleW;
  localparam int unsigned StepW  = $clog2(HW);

  typedef enum logic [2:0] {
    SC_IDLE = 3'b001,
    SC_MUL  = 3'b010,
    SC_DIV  = 3'b100
  } scale_state_e;

  scale_state_e                 state_q, state_d;
  logic [COUNT_BITS-1:0]        count_q;
  logic [COUNT_BITS-1:0]        peak_q;
  logic [ghist_pkg::ScaleW-1:0] scale_q;
  logic [ProdW-1:0]             rem_q, rem_d;
  logic [ProdW-1:0]             div_q, div_d;
  logic [HW-1:0]                quo_q, quo_d;
  logic [StepW-1:0]             step_q, step_d;
  logic                         done_q, done_d;
  logic                         fits;

  assign fits = (rem_q >= div_q);

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    div_d   = div_q;
    quo_d   = quo_q;
    step_d  = step_q;
    done_d  = 1'b0;
    case (state_q)
      SC_IDLE: begin
        if (start_i) begin
          state_d = SC_MUL;
        end
      end
      SC_MUL: begin
        rem_d   = ProdW'(count_q) * ProdW'(scale_q);
        div_d   = ProdW'(peak_q) << (HW - 1);
        quo_d   = '0;
        step_d  = StepW'(HW - 1);
        state_d = SC_DIV;
      end
      SC_DIV: begin
        if (fits) begin
          rem_d = rem_q - div_q;
        end
        quo_d = {quo_q[HW-2:0], fits};
        div_d = div_q >> 1;
        step_d = step_q - StepW'(1);
        if (step_q == '0) begin
          done_d  = 1'b1;
          state_d = SC_IDLE;
        end
      end
      default: begin
        state_d = SC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SC_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && (state_q == SC_IDLE)) begin
      count_q <= count_i;
      peak_q  <= peak_i;
      scale_q <= scale_i;
    end
    rem_q  <= rem_d;
    div_q  <= div_d;
    quo_q  <= quo_d;
    step_q <= step_d;
  end

  assign done_o   = done_q;
  assign height_o = (peak_q == '0) ? '0 : quo_q;

endmodule

[rtl/core/gray_histogram_normalized.sv]
// Gray-level histogram with a peak-normalized readout.
// Items enter on item_i and are taken at a rising edge with start high and
// busy low. A pixel transaction adds one to its bin, saturating at the
// largest count, and updates the peak; it holds busy for one cycle, so
// the next item waits out the read-modify-write of the bin memory, whose
// read is registered. A read transaction returns the bin count, the peak
// and floor(count * scale / peak) on result_o, strobed by result_valid_o
// for exactly one cycle; the next transaction is taken at the edge that
// ends it. A read passes through the memory read, a multiply step, ten
// restoring-division steps and two register stages before the strobe.
// A clear transaction sweeps the memory one bin per cycle. Out-of-range
// pixels and the unused kind are dropped without raising busy. After
// reset the block runs the same clearing pass with busy high. The scale
// register is written through cfg_valid_i and cfg_data_i at any time,
// resets to 300, and should only change while the block is idle. The
// receiver cannot stall the result.
module gray_histogram_normalized #(
  parameter int unsigned NUM_BINS   = ghist_pkg::NumBinsDef,
  parameter int unsigned COUNT_BITS = ghist_pkg::CountBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  ghist_pkg::item_t             item_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ghist_pkg::ScaleW-1:0] cfg_data_i,
  output logic                         result_valid_o,
  output ghist_pkg::result_t           result_o
);

  localparam int unsigned AddrW = $clog2(NUM_BINS);
  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};
  localparam logic [AddrW-1:0] LastAddr = AddrW'(NUM_BINS - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PIX   = 5'b00010,
    S_READ  = 5'b00100,
    S_SCALE = 5'b01000,
    S_CLEAR = 5'b10000
  } state_e;

  state_e                       state_q, state_d;
  logic [AddrW-1:0]             addr_q, addr_d;
  logic [AddrW-1:0]             clr_addr_q, clr_addr_d;
  logic                         in_range_q, in_range_d;
  logic [COUNT_BITS-1:0]        peak_q, peak_d;
  logic [COUNT_BITS-1:0]        count_q, count_d;
  logic [ghist_pkg::ScaleW-1:0] scale_q;
  logic                         valid_q, valid_d;
  ghist_pkg::result_t           result_q, result_d;

  logic                         accept;
  logic                         pix_in_range;
  logic                         sel_in_range;
  logic [AddrW-1:0]             raddr;
  logic                         mem_we;
  logic [AddrW-1:0]             mem_waddr;
  logic [COUNT_BITS-1:0]        mem_wdata;
  logic [COUNT_BITS-1:0]        mem_rdata;
  logic [COUNT_BITS-1:0]        read_count;
  logic [COUNT_BITS-1:0]        inc_count;
  logic                         scl_start;
  logic                         scl_done;
  logic [ghist_pkg::HeightW-1:0] scl_height;

  assign busy         = (state_q != S_IDLE);
  assign accept       = start && !busy;
  assign cfg_ready_o  = 1'b1;
  assign pix_in_range = (32'(item_i.gray_pixel) < NUM_BINS);
  assign sel_in_range = (32'(item_i.bin_select) < NUM_BINS);
  assign raddr        = (item_i.kind == ghist_pkg::KIND_READ) ?
                        AddrW'(item_i.bin_select) : AddrW'(item_i.gray_pixel);
  assign read_count   = in_range_q ? mem_rdata : '0;
  assign inc_count    = mem_rdata + COUNT_BITS'(1);

  always_comb begin
    state_d    = state_q;
    addr_d     = addr_q;
    clr_addr_d = clr_addr_q;
    in_range_d = in_range_q;
    peak_d     = peak_q;
    count_d    = count_q;
    valid_d    = 1'b0;
    result_d   = result_q;
    mem_we     = 1'b0;
    mem_waddr  = addr_q;
    mem_wdata  = inc_count;
    scl_start  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          addr_d = raddr;
          case (item_i.kind)
            ghist_pkg::KIND_PIXEL: begin
              if (pix_in_range) begin
                state_d = S_PIX;
              end
            end
            ghist_pkg::KIND_READ: begin
              in_range_d = sel_in_range;
              state_d    = S_READ;
            end
            ghist_pkg::KIND_CLEAR: begin
              clr_addr_d = '0;
              peak_d     = '0;
              state_d    = S_CLEAR;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_PIX: begin
        if (mem_rdata != CountMax) begin
          mem_we = 1'b1;
          if (inc_count > peak_q) begin
            peak_d = inc_count;
          end
        end
        state_d = S_IDLE;
      end
      S_READ: begin
        count_d   = read_count;
        scl_start = 1'b1;
        state_d   = S_SCALE;
      end
      S_SCALE: begin
        if (scl_done) begin
          result_d.bin_count  = ghist_pkg::OutCountW'(count_q);
          result_d.bin_height = scl_height;
          result_d.peak_count = ghist_pkg::OutCountW'(peak_q);
          valid_d             = 1'b1;
          state_d             = S_IDLE;
        end
      end
      S_CLEAR: begin
        mem_we     = 1'b1;
        mem_waddr  = clr_addr_q;
        mem_wdata  = '0;
        clr_addr_d = clr_addr_q + AddrW'(1);
        if (clr_addr_q == LastAddr) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_addr_q <= '0;
      peak_q     <= '0;
      scale_q    <= ghist_pkg::ScaleReset;
      valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      peak_q     <= peak_d;
      valid_q    <= valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        scale_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    in_range_q <= in_range_d;
    count_q    <= count_d;
    result_q   <= result_d;
  end

  ghist_mem #(
    .DEPTH (NUM_BINS),
    .WIDTH (COUNT_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (raddr),
    .rdata_o (mem_rdata)
  );

  ghist_scale #(
    .COUNT_BITS (COUNT_BITS)
  ) u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (scl_start),
    .count_i  (read_count),
    .peak_i   (peak_q),
    .scale_i  (scale_q),
    .done_o   (scl_done),
    .height_o (scl_height)
  );

  assign result_valid_o = valid_q;
  assign result_o       = result_q;

`ifndef SYNTHESIS
  a_strobe_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  a_height_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    scl_done |-> (scl_height <= scale_q))
    else $error("scaled height exceeds the full-scale height");

  a_read_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (item_i.kind == ghist_pkg::KIND_READ)) |=> busy)
    else $error("read transaction did not make the block busy");

  a_done_in_scale : assert property (@(posedge clk_i) disable iff (!rst_ni)
    scl_done |-> (state_q == S_SCALE))
    else $error("scale unit finished outside of a read");
`endif

endmodule

[tb/gray_histogram_normalized_tb.sv]
`timescale 1ns / 100ps

module gray_histogram_normalized_tb;
  import ghist_pkg::*;

  localparam int unsigned NumBins    = NumBinsDef;
  localparam int unsigned CountBits  = CountBitsDef;
  localparam logic [CountBits-1:0] CountMax = '1;
  localparam logic [KindW-1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned CycleLimit  = 600000;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                start          = 1'b0;
  logic                busy;
  item_t               item_i         = '0;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic [ScaleW-1:0]   cfg_data_i     = '0;
  logic                result_valid_o;
  result_t             result_o;

  logic [CountBits-1:0] hist_bins [NumBins];
  logic [CountBits-1:0] hist_peak;
  logic [ScaleW-1:0]    scale_setting;
  result_t              pending_reads [$];
  int unsigned          failures    = 0;
  int unsigned          cycle_count = 0;
  int unsigned          idle_pct    = 22;

  gray_histogram_normalized DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout with %0d reads outstanding", $time, pending_reads.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void clear_histogram();
    for (int i = 0; i < NumBins; i++) begin
      hist_bins[i] = '0;
    end
    hist_peak = '0;
  endfunction

  function automatic void predict_histogram(item_t it);
    logic [CountBits-1:0] cnt;
    logic [63:0]          quot;
    result_t              res;
    cnt  = '0;
    quot = '0;
    case (it.kind)
      KIND_PIXEL: begin
        if (int'(it.gray_pixel) < NumBins) begin
          cnt = hist_bins[it.gray_pixel];
          if (cnt != CountMax) begin
            cnt++;
            hist_bins[it.gray_pixel] = cnt;
            if (cnt > hist_peak) hist_peak = cnt;
          end
        end
      end
      KIND_READ: begin
        if (int'(it.bin_select) < NumBins) cnt = hist_bins[it.bin_select];
        if (hist_peak != 0) begin
          quot = (64'(cnt) * 64'(scale_setting)) / 64'(hist_peak);
        end
        res.bin_count  = cnt[OutCountW-1:0];
        res.bin_height = quot[HeightW-1:0];
        res.peak_count = hist_peak[OutCountW-1:0];
        pending_reads.push_back(res);
      end
      KIND_CLEAR: clear_histogram();
      default: ;
    endcase
  endfunction

  function automatic item_t make_item(logic [KindW-1:0] k, logic [PixelW-1:0] pix,
                                      logic [PixelW-1:0] sel);
    item_t it;
    it.kind       = k;
    it.gray_pixel = pix;
    it.bin_select = sel;
    return it;
  endfunction

  task automatic compare_field(input string name, input logic [OutCountW-1:0] want,
                               input logic [OutCountW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      if (pending_reads.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual count=%0d height=%0d peak=%0d",
                 $time, result_o.bin_count, result_o.bin_height, result_o.peak_count);
        failures++;
      end else begin
        want = pending_reads.pop_front();
        compare_field("bin_count", want.bin_count, result_o.bin_count);
        compare_field("bin_height", OutCountW'(want.bin_height), OutCountW'(result_o.bin_height));
        compare_field("peak_count", want.peak_count, result_o.peak_count);
      end
    end
  end

  task automatic send_item(input item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy !== 1'b0);
    predict_histogram(it);
  endtask

  // Stops the sender until every read has returned and a clear has had time to finish.
  task automatic settle();
    start <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_scale(input logic [ScaleW-1:0] value);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    scale_setting = value;
  endtask

  task automatic test_reads_when_empty();
    send_item(make_item(KIND_READ, 8'hFF, 8'h00));
    send_item(make_item(KIND_READ, 8'h00, 8'hFF));
    send_item(make_item(KIND_UNUSED, 8'hFF, 8'hFF));
  endtask

  task automatic test_directed_items();
    send_item(make_item(KIND_PIXEL, 8'h00, 8'hFF));
    send_item(make_item(KIND_PIXEL, 8'h00, 8'h00));
    send_item(make_item(KIND_PIXEL, 8'h00, 8'hAA));
    send_item(make_item(KIND_PIXEL, 8'hFF, 8'h55));
    send_item(make_item(KIND_PIXEL, 8'hAA, 8'h00));
    send_item(make_item(KIND_PIXEL, 8'h55, 8'hFF));
    send_item(make_item(KIND_UNUSED, 8'h00, 8'h00));
    send_item(make_item(KIND_READ, 8'hFF, 8'h00));
    send_item(make_item(KIND_READ, 8'h00, 8'hFF));
    send_item(make_item(KIND_READ, 8'h55, 8'hAA));
    send_item(make_item(KIND_READ, 8'hAA, 8'h13));
    send_item(make_item(KIND_CLEAR, 8'hFF, 8'hFF));
    send_item(make_item(KIND_READ, 8'h00, 8'h00));
    send_item(make_item(KIND_PIXEL, 8'h13, 8'h00));
    send_item(make_item(KIND_READ, 8'h00, 8'h13));
  endtask

  task automatic test_scale_extremes();
    write_scale(10'd1023);
    repeat (3) send_item(make_item(KIND_PIXEL, 8'h07, 8'h00));
    send_item(make_item(KIND_READ, 8'h00, 8'h07));
    send_item(make_item(KIND_READ, 8'h00, 8'h13));
    write_scale(10'd0);
    send_item(make_item(KIND_READ, 8'h00, 8'h07));
    write_scale(10'd1);
    send_item(make_item(KIND_READ, 8'h00, 8'h07));
    send_item(make_item(KIND_READ, 8'h00, 8'hFF));
  endtask

  function automatic logic [PixelW-1:0] pick_bin();
    logic [PixelW-1:0] hot [5] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};
    if ($urandom_range(1) == 0) return hot[$urandom_range(4)];
    return PixelW'($urandom_range(255));
  endfunction

  function automatic item_t random_item();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return make_item(KIND_PIXEL, pick_bin(), PixelW'($urandom_range(255)));
    if (r < 96) return make_item(KIND_READ, PixelW'($urandom_range(255)), pick_bin());
    if (r < 98) begin
      return make_item(KIND_UNUSED, PixelW'($urandom_range(255)), PixelW'($urandom_range(255)));
    end
    return make_item(KIND_CLEAR, PixelW'($urandom_range(255)), PixelW'($urandom_range(255)));
  endfunction

  task automatic test_random_traffic();
    logic [ScaleW-1:0] scales [6];
    scales = '{10'd1023, 10'd1, 10'd300, 10'd0, ScaleW'($urandom_range(1, 1023)), 10'd512};
    for (int phase = 0; phase < 6; phase++) begin
      write_scale(scales[phase]);
      idle_pct = (phase == 2) ? 0 : 22;
      repeat (300) send_item(random_item());
    end
    idle_pct = 22;
  endtask

  initial begin
    scale_setting = ScaleReset;
    clear_histogram();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reads_when_empty();
    test_directed_items();
    test_scale_extremes();
    test_random_traffic();
    settle();
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/ghist_pkg.sv
rtl/core/ghist_mem.sv
rtl/core/ghist_scale.sv
rtl/core/gray_histogram_normalized.sv
tb/gray_histogram_normalized_tb.sv
